### hw/rtl/ordered_list_engine_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef ORDERED_LIST_ENGINE_UNIT_MACROS_SVH
`define ORDERED_LIST_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on aclk and disabled while in reset.
`define OLE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and disabled while in reset.
`define OLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/olist_pkg.sv
package olist_pkg;

    localparam int CAPACITY_DEF    = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int ACTION_W = 3;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 40;

    localparam int S_ACTION_LSB = 0;
    localparam int S_VALUE_LSB  = S_ACTION_LSB + ACTION_W;
    localparam int S_KEY_LSB    = S_VALUE_LSB + DATA_W;
    localparam int M_STATUS_LSB = 0;
    localparam int M_ITEM_LSB   = M_STATUS_LSB + STATUS_W;
    localparam int M_COUNT_LSB  = M_ITEM_LSB + DATA_W;
    localparam int M_USED_W     = M_COUNT_LSB + COUNT_W;

    localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_INSERT     = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_DELETE     = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic value_en;
        logic link_en;
    } mem_wr_t;

endpackage

### hw/rtl/olist_mem.sv
module olist_mem
    import olist_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic                          aclk,
    input  mem_wr_t                       wr,
    input  logic [IDX_W-1:0]              wr_addr,
    input  logic signed [VALUE_WIDTH-1:0] wr_value,
    input  logic [IDX_W-1:0]              wr_link,
    input  logic [IDX_W-1:0]              rd_addr,
    output logic signed [VALUE_WIDTH-1:0] rd_value_reg,
    output logic [IDX_W-1:0]              rd_link_reg
);

    logic signed [VALUE_WIDTH-1:0] values_mem [CAPACITY];
    logic [IDX_W-1:0]              links_mem  [CAPACITY];

    always_ff @(posedge aclk) begin
        if (wr.value_en) begin
            values_mem[wr_addr] <= wr_value;
        end
        if (wr.link_en) begin
            links_mem[wr_addr] <= wr_link;
        end
        rd_value_reg <= values_mem[rd_addr];
        rd_link_reg  <= links_mem[rd_addr];
    end

endmodule

### hw/rtl/olist_ctrl.sv
module olist_ctrl
    import olist_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CNT_W      = $clog2(CAPACITY + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic [ACTION_W-1:0]           req_action,
    input  logic signed [DATA_W-1:0]      req_value,
    input  logic signed [DATA_W-1:0]      req_key,
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic [STATUS_W-1:0]           res_status,
    output logic signed [VALUE_WIDTH-1:0] res_item,
    output logic [CNT_W-1:0]              res_count,
    output mem_wr_t                       wr,
    output logic [IDX_W-1:0]              wr_addr,
    output logic signed [VALUE_WIDTH-1:0] wr_value,
    output logic [IDX_W-1:0]              wr_link,
    output logic [IDX_W-1:0]              rd_addr,
    input  logic signed [VALUE_WIDTH-1:0] rd_value,
    input  logic [IDX_W-1:0]              rd_link
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_START  = 4'd1;
    localparam logic [3:0] S_SEARCH = 4'd2;
    localparam logic [3:0] S_POPF   = 4'd3;
    localparam logic [3:0] S_PBVAL  = 4'd4;
    localparam logic [3:0] S_PBWALK = 4'd5;
    localparam logic [3:0] S_LINK   = 4'd6;
    localparam logic [3:0] S_DONE   = 4'd7;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    logic [3:0]                    state_reg, state_next;
    logic [ACTION_W-1:0]           act_reg, act_next;
    logic signed [VALUE_WIDTH-1:0] val_reg, val_next;
    logic signed [VALUE_WIDTH-1:0] key_reg, key_next;
    logic [IDX_W-1:0]              first_reg, first_next;
    logic [IDX_W-1:0]              last_reg, last_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [CAPACITY-1:0]           in_use_reg, in_use_next;
    logic [IDX_W-1:0]              cur_reg, cur_next;
    logic [IDX_W-1:0]              prev_reg, prev_next;
    logic [CNT_W-1:0]              step_reg, step_next;
    logic [IDX_W-1:0]              slot_reg, slot_next;
    logic [IDX_W-1:0]              link_addr_reg, link_addr_next;
    logic [STATUS_W-1:0]           status_reg, status_next;
    logic signed [VALUE_WIDTH-1:0] item_reg, item_next;
    logic [IDX_W-1:0]              free_idx;

    always_comb begin
        free_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!in_use_reg[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign req_ready  = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_DONE);
    assign res_status = status_reg;
    assign res_item   = item_reg;
    assign res_count  = cnt_reg;

    always_comb begin
        state_next     = state_reg;
        act_next       = act_reg;
        val_next       = val_reg;
        key_next       = key_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        cnt_next       = cnt_reg;
        in_use_next    = in_use_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        step_next      = step_reg;
        slot_next      = slot_reg;
        link_addr_next = link_addr_reg;
        status_next    = status_reg;
        item_next      = item_reg;
        wr             = '0;
        wr_addr        = free_idx;
        wr_value       = val_reg;
        wr_link        = first_reg;
        rd_addr        = cur_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    act_next   = req_action;
                    val_next   = VALUE_WIDTH'(req_value);
                    key_next   = VALUE_WIDTH'(req_key);
                    state_next = S_START;
                end
            end
            S_START: begin
                status_next = ST_OK;
                item_next   = '0;
                state_next  = S_DONE;
                case (act_reg) inside
                    ACT_PUSH_FRONT, ACT_PUSH_BACK, ACT_INSERT: begin
                        if (cnt_reg == CNT_FULL) begin
                            status_next = ST_FULL;
                        end else if (cnt_reg == '0) begin
                            wr                    = '{value_en: 1'b1, link_en: 1'b1};
                            wr_link               = free_idx;
                            in_use_next[free_idx] = 1'b1;
                            first_next            = free_idx;
                            last_next             = free_idx;
                            cnt_next              = CNT_ONE;
                            item_next             = val_reg;
                        end else if (act_reg == ACT_INSERT) begin
                            cur_next   = first_reg;
                            prev_next  = last_reg;
                            step_next  = '0;
                            rd_addr    = first_reg;
                            state_next = S_SEARCH;
                        end else begin
                            wr                    = '{value_en: 1'b1, link_en: 1'b1};
                            in_use_next[free_idx] = 1'b1;
                            slot_next             = free_idx;
                            link_addr_next        = last_reg;
                            if (act_reg == ACT_PUSH_FRONT) begin
                                first_next = free_idx;
                            end else begin
                                last_next = free_idx;
                            end
                            cnt_next   = cnt_reg + CNT_ONE;
                            item_next  = val_reg;
                            state_next = S_LINK;
                        end
                    end
                    ACT_POP_FRONT, ACT_POP_BACK, ACT_DELETE: begin
                        if (cnt_reg == '0) begin
                            status_next = ST_EMPTY;
                        end else if (act_reg == ACT_POP_FRONT) begin
                            rd_addr    = first_reg;
                            state_next = S_POPF;
                        end else if (act_reg == ACT_POP_BACK) begin
                            rd_addr    = last_reg;
                            state_next = S_PBVAL;
                        end else begin
                            cur_next   = first_reg;
                            prev_next  = last_reg;
                            step_next  = '0;
                            rd_addr    = first_reg;
                            state_next = S_SEARCH;
                        end
                    end
                    default: ;
                endcase
            end
            S_SEARCH: begin
                if (rd_value == key_reg) begin
                    status_next = ST_OK;
                    state_next  = S_DONE;
                    if (act_reg == ACT_INSERT) begin
                        wr                    = '{value_en: 1'b1, link_en: 1'b1};
                        wr_link               = rd_link;
                        in_use_next[free_idx] = 1'b1;
                        slot_next             = free_idx;
                        link_addr_next        = cur_reg;
                        if (cur_reg == last_reg) begin
                            last_next = free_idx;
                        end
                        cnt_next   = cnt_reg + CNT_ONE;
                        item_next  = val_reg;
                        state_next = S_LINK;
                    end else begin
                        item_next            = rd_value;
                        in_use_next[cur_reg] = 1'b0;
                        if (cnt_reg == CNT_ONE) begin
                            first_next = '0;
                            last_next  = '0;
                            cnt_next   = '0;
                        end else if (cur_reg == first_reg) begin
                            first_next = rd_link;
                            wr         = '{value_en: 1'b0, link_en: 1'b1};
                            wr_addr    = last_reg;
                            wr_link    = rd_link;
                            cnt_next   = cnt_reg - CNT_ONE;
                        end else begin
                            wr      = '{value_en: 1'b0, link_en: 1'b1};
                            wr_addr = prev_reg;
                            wr_link = rd_link;
                            if (cur_reg == last_reg) begin
                                last_next = prev_reg;
                            end
                            cnt_next = cnt_reg - CNT_ONE;
                        end
                    end
                end else if ((step_reg + CNT_ONE) == cnt_reg) begin
                    status_next = ST_NOT_FOUND;
                    item_next   = '0;
                    state_next  = S_DONE;
                end else begin
                    prev_next = cur_reg;
                    cur_next  = rd_link;
                    rd_addr   = rd_link;
                    step_next = step_reg + CNT_ONE;
                end
            end
            S_POPF: begin
                item_next              = rd_value;
                in_use_next[first_reg] = 1'b0;
                state_next             = S_DONE;
                if (cnt_reg == CNT_ONE) begin
                    first_next = '0;
                    last_next  = '0;
                    cnt_next   = '0;
                end else begin
                    first_next = rd_link;
                    wr         = '{value_en: 1'b0, link_en: 1'b1};
                    wr_addr    = last_reg;
                    wr_link    = rd_link;
                    cnt_next   = cnt_reg - CNT_ONE;
                end
            end
            S_PBVAL: begin
                item_next = rd_value;
                if (cnt_reg == CNT_ONE) begin
                    in_use_next[last_reg] = 1'b0;
                    first_next            = '0;
                    last_next             = '0;
                    cnt_next              = '0;
                    state_next            = S_DONE;
                end else begin
                    cur_next   = first_reg;
                    rd_addr    = first_reg;
                    state_next = S_PBWALK;
                end
            end
            S_PBWALK: begin
                if (rd_link == last_reg) begin
                    wr                    = '{value_en: 1'b0, link_en: 1'b1};
                    wr_addr               = cur_reg;
                    wr_link               = first_reg;
                    in_use_next[last_reg] = 1'b0;
                    last_next             = cur_reg;
                    cnt_next              = cnt_reg - CNT_ONE;
                    state_next            = S_DONE;
                end else begin
                    cur_next = rd_link;
                    rd_addr  = rd_link;
                end
            end
            S_LINK: begin
                wr         = '{value_en: 1'b0, link_en: 1'b1};
                wr_addr    = link_addr_reg;
                wr_link    = slot_reg;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            first_reg  <= '0;
            last_reg   <= '0;
            cnt_reg    <= '0;
            in_use_reg <= '0;
        end else begin
            state_reg  <= state_next;
            first_reg  <= first_next;
            last_reg   <= last_next;
            cnt_reg    <= cnt_next;
            in_use_reg <= in_use_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg       <= act_next;
        val_reg       <= val_next;
        key_reg       <= key_next;
        cur_reg       <= cur_next;
        prev_reg      <= prev_next;
        step_reg      <= step_next;
        slot_reg      <= slot_next;
        link_addr_reg <= link_addr_next;
        status_reg    <= status_next;
        item_reg      <= item_next;
    end

endmodule

### hw/rtl/ordered_list_engine_unit.sv
// Channel   Direction  tdata fields (low bit first)            tuser
// s_        in         action[2:0] value[34:3] key[66:35]      none
// m_        out        status[1:0] item_value[33:2] count[38:34] none
//
// Push front and push back write the new entry, then link it in; pop front reads the head
// entry. A full, empty or unused request and a push into an empty list go straight to the
// result. Insert after key walks one entry per cycle; delete and pop back walk the same way.
// Reset empties the list at once. A new request is taken the cycle after the result moves to
// the output register, even while it still waits on m_tready; the next result then waits
// until the output register is free.
module ordered_list_engine_unit
    import olist_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // action, value, key
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // status, item_value, entry_count
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                          res_valid;
    logic                          res_ready;
    logic [STATUS_W-1:0]           res_status;
    logic signed [VALUE_WIDTH-1:0] res_item;
    logic [CNT_W-1:0]              res_count;
    mem_wr_t                       wr;
    logic [IDX_W-1:0]              wr_addr;
    logic signed [VALUE_WIDTH-1:0] wr_value;
    logic [IDX_W-1:0]              wr_link;
    logic [IDX_W-1:0]              rd_addr;
    logic signed [VALUE_WIDTH-1:0] rd_value;
    logic [IDX_W-1:0]              rd_link;

    logic                          m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]          m_tdata_reg, m_tdata_next;
    logic signed [DATA_W-1:0]      item_out;

    olist_ctrl #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req_valid  (s_tvalid),
        .req_ready  (s_tready),
        .req_action (s_tdata[S_ACTION_LSB +: ACTION_W]),
        .req_value  (s_tdata[S_VALUE_LSB +: DATA_W]),
        .req_key    (s_tdata[S_KEY_LSB +: DATA_W]),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_status (res_status),
        .res_item   (res_item),
        .res_count  (res_count),
        .wr         (wr),
        .wr_addr    (wr_addr),
        .wr_value   (wr_value),
        .wr_link    (wr_link),
        .rd_addr    (rd_addr),
        .rd_value   (rd_value),
        .rd_link    (rd_link)
    );

    olist_mem #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_mem (
        .aclk         (aclk),
        .wr           (wr),
        .wr_addr      (wr_addr),
        .wr_value     (wr_value),
        .wr_link      (wr_link),
        .rd_addr      (rd_addr),
        .rd_value_reg (rd_value),
        .rd_link_reg  (rd_link)
    );

    assign res_ready = !m_tvalid_reg || m_tready;
    assign item_out  = DATA_W'(res_item);

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {
                {(M_TDATA_W - M_USED_W){1'b0}},
                COUNT_W'(res_count),
                item_out,
                res_status
            };
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### hw/rtl/olist_checker.sv
`include "ordered_list_engine_unit_macros.svh"

module olist_checker
    import olist_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic [STATUS_W-1:0] st;
    logic [DATA_W-1:0]   item;
    logic [COUNT_W-1:0]  cnt;
    logic                stall;
    logic                is_full;
    logic                is_empty;
    logic                is_fail;

    assign st       = m_tdata[M_STATUS_LSB +: STATUS_W];
    assign item     = m_tdata[M_ITEM_LSB +: DATA_W];
    assign cnt      = m_tdata[M_COUNT_LSB +: COUNT_W];
    assign stall    = m_tvalid && !m_tready;
    assign is_full  = m_tvalid && (st == ST_FULL);
    assign is_empty = m_tvalid && (st == ST_EMPTY);
    assign is_fail  = m_tvalid && (st != ST_OK);

    `OLE_ASSERT_NEXT(a_out_hold, stall, m_tvalid && $stable(m_tdata), "Stalled result changed")
    `OLE_ASSERT_NOW(a_full_count, is_full, cnt == COUNT_W'(CAPACITY), "Full status, low count")
    `OLE_ASSERT_NOW(a_empty_count, is_empty, cnt == '0, "Empty status with a nonzero count")
    `OLE_ASSERT_NOW(a_fail_item, is_fail, item == '0, "Failed request carries a nonzero item")

endmodule

bind ordered_list_engine_unit olist_checker #(.CAPACITY(CAPACITY)) u_olist_checker (.*);
